>>> design/gyro_pointer_smoothing_unit_assert.svh
// ----------------------------------------------------------------------------
// Gyro pointer smoothing unit - assertion macros
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef GYRO_POINTER_SMOOTHING_UNIT_ASSERT_SVH
`define GYRO_POINTER_SMOOTHING_UNIT_ASSERT_SVH

// Same-cycle implication
`define GPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define GPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg
// Field widths, register indexes and shared types for the gyro pointer
// smoothing unit.
// ----------------------------------------------------------------------------
package gps_pkg;

    // Field widths
    localparam int RATE_W  = 16;
    localparam int LIMIT_W = 16;
    localparam int CUR_W   = 16;
    localparam int BIAS_W  = 24;
    localparam int SCALE_W = 21;
    localparam int ALPHA_W = 17;
    localparam int ST_W    = 40;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_BIAS_X       = 3'd0;
    localparam logic [IDX_W-1:0] REG_BIAS_Y       = 3'd1;
    localparam logic [IDX_W-1:0] REG_BIAS_Z       = 3'd2;
    localparam logic [IDX_W-1:0] REG_SCALE_X      = 3'd3;
    localparam logic [IDX_W-1:0] REG_SCALE_Y      = 3'd4;
    localparam logic [IDX_W-1:0] REG_SCALE_Z      = 3'd5;
    localparam logic [IDX_W-1:0] REG_SMOOTHING    = 3'd6;
    localparam logic [IDX_W-1:0] REG_POINTER_GAIN = 3'd7;

    // Reset values
    localparam logic [SCALE_W-1:0] SCALE_RESET = 21'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd65536;
    localparam logic [ALPHA_W-1:0] GAIN_RESET  = 17'd65536;

    // Stage load strobes shared by all lanes
    typedef struct packed {
        logic ld_x;      // input transaction accepted
        logic ld_prod;   // bias-corrected value ready
        logic ld_mix;    // scaled product ready
        logic ld_state;  // smoothing products ready
    } lane_ctrl_t;

endpackage

>>> design/gps_lane.sv
// ----------------------------------------------------------------------------
// gps_lane
// One axis: bias correction, scaling and exponential smoothing update.
// Four registered steps; owns the axis smoothing state.
// ----------------------------------------------------------------------------
module gps_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  gps_pkg::lane_ctrl_t                ctrl,
    input  logic signed [gps_pkg::RATE_W-1:0]  raw,
    input  logic signed [gps_pkg::BIAS_W-1:0]  bias,
    input  logic signed [gps_pkg::SCALE_W-1:0] scale,
    input  logic        [gps_pkg::ALPHA_W-1:0] alpha,
    output logic signed [gps_pkg::ST_W-1:0]    state
);
    import gps_pkg::*;

    localparam int SHW = RATE_W + FRAC_BITS;
    localparam int XW  = ((SHW > BIAS_W) ? SHW : BIAS_W) + 1;
    localparam int PW  = XW + SCALE_W;
    localparam int CW  = PW - FRAC_BITS;
    localparam int OMW = ((FRAC_BITS + 2) > (ALPHA_W + 1)) ? (FRAC_BITS + 2) : (ALPHA_W + 1);
    localparam int AW  = CW + ALPHA_W + 1;
    localparam int BW  = OMW + ST_W;
    localparam int EW  = ST_W + FRAC_BITS;

    logic signed [XW-1:0]      x_reg, x_next;
    logic signed [PW-1:0]      prod_reg, prod_next;
    logic signed [CW-1:0]      corr;
    logic signed [ALPHA_W:0]   alpha_s;
    logic signed [OMW-1:0]     one_minus;
    logic signed [AW-1:0]      pa_reg, pa_next;
    logic signed [BW-1:0]      pb_reg, pb_next;
    logic signed [EW-1:0]      pa_ext, pb_ext;
    logic signed [ST_W-1:0]    state_reg, state_next;

    // Step 1: move sample into fixed point, remove bias
    assign x_next = (XW'(raw) <<< FRAC_BITS) - XW'(bias);

    // Step 2: apply axis scale
    assign prod_next = PW'(x_reg) * PW'(scale);

    // Step 3: floor the scaled value, weight new and old values
    assign corr      = prod_reg[PW-1:FRAC_BITS];
    assign alpha_s   = $signed({1'b0, alpha});
    assign one_minus = (OMW'(1) <<< FRAC_BITS) - OMW'(alpha_s);
    assign pa_next   = AW'(alpha_s) * AW'(corr);
    assign pb_next   = BW'(one_minus) * BW'(state_reg);

    // Step 4: floor both products, sum wraps to the state width
    assign pa_ext     = EW'(pa_reg);
    assign pb_ext     = EW'(pb_reg);
    assign state_next = pa_ext[EW-1:FRAC_BITS] + pb_ext[EW-1:FRAC_BITS];

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (ctrl.ld_x) begin
            x_reg <= x_next;
        end
        if (ctrl.ld_prod) begin
            prod_reg <= prod_next;
        end
        if (ctrl.ld_mix) begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
    end

    // Smoothing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (ctrl.ld_state) begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

>>> design/gps_merge.sv
// ----------------------------------------------------------------------------
// gps_merge
// Combines the x and z lanes: cursor steps from the pointer gain and the
// motion limit check.
// ----------------------------------------------------------------------------
module gps_merge #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               ld,
    input  logic signed [gps_pkg::ST_W-1:0]    s_x,
    input  logic signed [gps_pkg::ST_W-1:0]    s_z,
    input  logic        [gps_pkg::ALPHA_W-1:0] gain,
    input  logic        [gps_pkg::LIMIT_W-1:0] limit,
    output logic signed [gps_pkg::CUR_W-1:0]   dx,
    output logic signed [gps_pkg::CUR_W-1:0]   dy,
    output logic                               over
);
    import gps_pkg::*;

    localparam int GMW = ST_W + ALPHA_W + 1;
    localparam int GEW = 2 * FRAC_BITS + CUR_W;

    logic signed [ALPHA_W:0] gain_s;
    logic signed [GMW-1:0]   pdx_reg, pdx_next;
    logic signed [GMW-1:0]   pdy_reg, pdy_next;
    logic signed [GEW-1:0]   pdx_ext, pdy_ext;
    logic        [ST_W-1:0]  mag_x, mag_z, lim;
    logic                    over_reg, over_next;

    // Gain products
    assign gain_s   = $signed({1'b0, gain});
    assign pdx_next = GMW'(s_z) * GMW'(gain_s);
    assign pdy_next = GMW'(s_x) * GMW'(gain_s);

    // Magnitude check against the limit in fixed point
    assign mag_x     = s_x[ST_W-1] ? ST_W'(-s_x) : ST_W'(s_x);
    assign mag_z     = s_z[ST_W-1] ? ST_W'(-s_z) : ST_W'(s_z);
    assign lim       = ST_W'(limit) << FRAC_BITS;
    assign over_next = (mag_x > lim) || (mag_z > lim);

    always_ff @(posedge aclk) begin
        if (ld) begin
            pdx_reg  <= pdx_next;
            pdy_reg  <= pdy_next;
            over_reg <= over_next;
        end
    end

    // Floor by two fraction widths, keep low cursor bits
    assign pdx_ext = GEW'(pdx_reg);
    assign pdy_ext = GEW'(pdy_reg);
    assign dx      = pdx_ext[GEW-1:2*FRAC_BITS];
    assign dy      = pdy_ext[GEW-1:2*FRAC_BITS];
    assign over    = over_reg;

endmodule

>>> design/gyro_pointer_smoothing_unit.sv
// ----------------------------------------------------------------------------
// Gyro pointer smoothing unit
// Turns one three-axis gyro transaction into a cursor step. Each axis runs in
// its own lane: the sample is moved into fixed point, the bias removed, the
// scale applied and the exponential smoothing state updated; a merge stage
// scales the smoothed z and x rates by the pointer gain into dx and dy and
// flags a smoothed |x| or |z| above the motion limit. One transaction is in
// flight at a time. It passes four lane steps (bias subtract, scale multiply,
// the two smoothing multiplies, state sum) and one merge step (gain
// multiplies), then lands in the output register, which frees the pipeline:
// the next transaction may be accepted while a result waits, but not before
// the last one has moved into the output register.
// Configuration writes take effect at once and belong between transactions.
// ----------------------------------------------------------------------------
`include "gyro_pointer_smoothing_unit_assert.svh"

module gyro_pointer_smoothing_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic        [gps_pkg::IDX_W-1:0]   cfg_index,
    input  logic        [gps_pkg::CFG_W-1:0]   cfg_wdata,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [gps_pkg::RATE_W-1:0]  s_rate_x,
    input  logic signed [gps_pkg::RATE_W-1:0]  s_rate_y,
    input  logic signed [gps_pkg::RATE_W-1:0]  s_rate_z,
    input  logic        [gps_pkg::LIMIT_W-1:0] s_motion_limit,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [gps_pkg::CUR_W-1:0]   m_cursor_dx,
    output logic signed [gps_pkg::CUR_W-1:0]   m_cursor_dy,
    output logic                               m_over_limit,
    output logic signed [gps_pkg::ST_W-1:0]    m_smooth_x,
    output logic signed [gps_pkg::ST_W-1:0]    m_smooth_y,
    output logic signed [gps_pkg::ST_W-1:0]    m_smooth_z
);
    import gps_pkg::*;

    // Configuration registers
    logic signed [BIAS_W-1:0]  bias_x_reg, bias_y_reg, bias_z_reg;
    logic signed [SCALE_W-1:0] scale_x_reg, scale_y_reg, scale_z_reg;
    logic        [ALPHA_W-1:0] smoothing_reg, pointer_gain_reg;

    // Pipeline control
    logic       accept;
    logic       v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v5_next;
    logic       out_load;
    logic       m_valid_reg, m_valid_next;
    lane_ctrl_t lane_ctrl;

    // Datapath
    logic        [LIMIT_W-1:0] limit_reg;
    logic signed [ST_W-1:0]    st_x, st_y, st_z;
    logic signed [CUR_W-1:0]   mg_dx, mg_dy;
    logic                      mg_over;
    logic signed [CUR_W-1:0]   dx_reg, dy_reg;
    logic                      over_reg;
    logic signed [ST_W-1:0]    sx_reg, sy_reg, sz_reg;

    // Register writes; unused indexes do not exist with a 3-bit index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_x_reg       <= '0;
            bias_y_reg       <= '0;
            bias_z_reg       <= '0;
            scale_x_reg      <= SCALE_RESET;
            scale_y_reg      <= SCALE_RESET;
            scale_z_reg      <= SCALE_RESET;
            smoothing_reg    <= ALPHA_RESET;
            pointer_gain_reg <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BIAS_X:       bias_x_reg       <= cfg_wdata;
                REG_BIAS_Y:       bias_y_reg       <= cfg_wdata;
                REG_BIAS_Z:       bias_z_reg       <= cfg_wdata;
                REG_SCALE_X:      scale_x_reg      <= cfg_wdata[SCALE_W-1:0];
                REG_SCALE_Y:      scale_y_reg      <= cfg_wdata[SCALE_W-1:0];
                REG_SCALE_Z:      scale_z_reg      <= cfg_wdata[SCALE_W-1:0];
                REG_SMOOTHING:    smoothing_reg    <= cfg_wdata[ALPHA_W-1:0];
                REG_POINTER_GAIN: pointer_gain_reg <= cfg_wdata[ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stage valids: one transaction in flight, held at the last stage
    // until the output register is free
    assign s_ready      = !(v1_reg || v2_reg || v3_reg || v4_reg || v5_reg);
    assign accept       = s_valid && s_ready;
    assign out_load     = v5_reg && (!m_valid_reg || m_ready);
    assign v5_next      = v4_reg || (v5_reg && !out_load);
    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= accept;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v5_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign lane_ctrl.ld_x     = accept;
    assign lane_ctrl.ld_prod  = v1_reg;
    assign lane_ctrl.ld_mix   = v2_reg;
    assign lane_ctrl.ld_state = v3_reg;

    // Limit is needed at the merge step
    always_ff @(posedge aclk) begin
        if (accept) begin
            limit_reg <= s_motion_limit;
        end
    end

    // Axis lanes
    gps_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (lane_ctrl),
        .raw     (s_rate_x),
        .bias    (bias_x_reg),
        .scale   (scale_x_reg),
        .alpha   (smoothing_reg),
        .state   (st_x)
    );

    gps_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (lane_ctrl),
        .raw     (s_rate_y),
        .bias    (bias_y_reg),
        .scale   (scale_y_reg),
        .alpha   (smoothing_reg),
        .state   (st_y)
    );

    gps_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (lane_ctrl),
        .raw     (s_rate_z),
        .bias    (bias_z_reg),
        .scale   (scale_z_reg),
        .alpha   (smoothing_reg),
        .state   (st_z)
    );

    // Merge: cursor steps and limit flag
    gps_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .aclk  (aclk),
        .ld    (v4_reg),
        .s_x   (st_x),
        .s_z   (st_z),
        .gain  (pointer_gain_reg),
        .limit (limit_reg),
        .dx    (mg_dx),
        .dy    (mg_dy),
        .over  (mg_over)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            dx_reg   <= mg_dx;
            dy_reg   <= mg_dy;
            over_reg <= mg_over;
            sx_reg   <= st_x;
            sy_reg   <= st_y;
            sz_reg   <= st_z;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_dx  = dx_reg;
    assign m_cursor_dy  = dy_reg;
    assign m_over_limit = over_reg;
    assign m_smooth_x   = sx_reg;
    assign m_smooth_y   = sy_reg;
    assign m_smooth_z   = sz_reg;

    // Checks
    `GPS_ASSERT_NOW(a_one_in_flight, 1'b1,
        $onehot0({v1_reg, v2_reg, v3_reg, v4_reg, v5_reg}),
        "more than one transaction in the pipeline")
    `GPS_ASSERT_NEXT(a_state_hold, !v3_reg,
        $stable(st_x) && $stable(st_y) && $stable(st_z),
        "smoothing state changed outside its update step")
    `GPS_ASSERT_NEXT(a_result_moves, v5_reg && !m_valid_reg,
        m_valid && !v5_reg,
        "finished transaction not moved into an empty output register")
    `GPS_ASSERT_NOW(a_busy_no_accept, v1_reg || v5_reg,
        !s_ready,
        "input accepted while a transaction is in flight")

endmodule
